### sv/tcrc_pkg.sv
// Package for the two-class register colorer: shared types, sizes and codes.
// Used by two_class_register_colorer_core and the testbench; depends on nothing.
package tcrc_pkg;

   localparam int MaxVertices = 64;
   localparam int VidxWidth   = 6;
   localparam int EntryWidth  = 7;   // class bit above a 6-bit color

   typedef logic [5:0]        vidx_type;
   typedef logic [5:0]        color_type;
   typedef logic [6:0]        count_type;
   typedef logic [6:0]        counter_type;
   typedef logic signed [8:0] slot_type;
   typedef logic [7:0]        reg_count_type;
   typedef logic [63:0]       mask_type;
   typedef logic [1:0]        csr_index_type;
   typedef logic [EntryWidth-1:0] entry_type;

   // register indexes on the csr channel
   localparam csr_index_type CsrSavedCount     = 2'd0;
   localparam csr_index_type CsrClobberedCount = 2'd1;

   // position of the lowest clear bit in a byte (seven when the byte is full)
   function automatic logic [2:0] lowest_zero(input logic [7:0] bits);
      logic [2:0] pos;
      pos = 3'd7;
      for (int k = 7; k >= 0; k--) begin
         if (!bits[k]) begin
            pos = 3'(k);
         end
      end
      return pos;
   endfunction

endpackage

### sv/two_class_register_colorer_core.sv
// Top level of the two-class register colorer.
// Depends on tcrc_pkg and tcrc_ram (class/color store of earlier vertices).
//
// Use: each request on req_* is one vertex of an interference graph: its class
// (req_is_saved) and a mask of edges to earlier vertices of the same graph.
// req_new_graph restarts numbering at zero. One response on rsp_* follows each
// request: vertex index, color, counter priority and the placement (saved
// register, clobbered register or memory slot). Register counts are written on
// csr_* (index 0 saved count, index 1 clobbered count, other indexes ignored)
// while the block is idle; csr_ready is always high.
// Sequence: a vertex with index n > 0 first reads the earlier vertices out
// of the store (one read per cycle through its single read port; the scan
// closes once the last read has landed; index zero has nothing to read),
// then searches for a free color (one byte of the used-color set per
// cycle, lowest byte first) and then takes its placement step. req_ready
// is high only while the sequencer is idle, so the next request is taken
// while the previous response still waits in its register. An overflow
// vertex (graph already full) skips the scan and the search and goes
// straight to its placement step.
// Reset empties the graph and clears both register counts. A stalled receiver
// holds the response; the sequencer then waits in its placement step.
module two_class_register_colorer_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_new_graph,
   input  logic                    req_is_saved,
   input  tcrc_pkg::mask_type      req_neighbor_mask,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tcrc_pkg::vidx_type      rsp_vertex_index,
   output tcrc_pkg::color_type     rsp_color_priority,
   output tcrc_pkg::counter_type   rsp_counter_priority,
   output logic                    rsp_in_register,
   output tcrc_pkg::slot_type      rsp_slot_offset,
   output logic                    rsp_overflow,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  tcrc_pkg::csr_index_type csr_index,
   input  tcrc_pkg::reg_count_type csr_data
);
   import tcrc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_PLACE  = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   count_type     count_ff, count_in;
   reg_count_type saved_cnt_ff, saved_cnt_in;
   reg_count_type clob_cnt_ff, clob_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          pend_ff, pend_in;

   // working registers of the current request
   vidx_type      idx_ff, idx_in;
   logic          cls_ff, cls_in;
   logic          ovf_ff, ovf_in;
   mask_type      mask_ff, mask_in;
   mask_type      used_ff, used_in;
   counter_type   counter_ff, counter_in;
   count_type     scan_ff, scan_in;
   logic          pend_bit_ff, pend_bit_in;
   logic [2:0]    chunk_ff, chunk_in;
   color_type     color_ff, color_in;

   // response registers
   vidx_type      out_idx_ff, out_idx_in;
   color_type     out_color_ff, out_color_in;
   counter_type   out_counter_ff, out_counter_in;
   logic          out_reg_ff, out_reg_in;
   slot_type      out_slot_ff, out_slot_in;
   logic          out_ovf_ff, out_ovf_in;

   // store port signals
   logic          ram_wr_en;
   entry_type     ram_wr_data;
   vidx_type      ram_rd_addr;
   entry_type     ram_rd_data;

   // placement arithmetic
   logic signed [10:0] s_val, c_val, col_val, cnt_val, d_val, disp_val;
   logic          place_reg;
   logic          issue;
   logic          rsp_free;
   logic          req_fire;
   logic [7:0]    chunk_bits;

   tcrc_ram #(
      .WIDTH(EntryWidth),
      .DEPTH(MaxVertices)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign issue     = scan_ff < {1'b0, idx_ff};
   assign ram_rd_addr = scan_ff[VidxWidth-1:0];
   assign ram_wr_data = {cls_ff, color_ff};
   assign ram_wr_en   = (state_ff == ST_PLACE) && rsp_free && !ovf_ff;

   // byte of the used-color set under test; colour 63 always counts as free
   always_comb begin
      if (chunk_ff == 3'd7) begin
         chunk_bits = {1'b0, used_ff[62:56]};
      end else begin
         chunk_bits = used_ff[{chunk_ff, 3'b000} +: 8];
      end
   end

   // placement from colour, counter priority and register counts
   always_comb begin
      s_val   = 11'(signed'({3'b000, saved_cnt_ff}));
      c_val   = 11'(signed'({3'b000, clob_cnt_ff}));
      col_val = 11'(signed'({5'b00000, color_ff}));
      cnt_val = 11'(signed'({4'b0000, counter_ff}));
      if (cls_ff) begin
         d_val = s_val - col_val - 11'sd1;
         place_reg = (d_val >= 11'sd0) && (cnt_val <= d_val + c_val);
         disp_val  = place_reg ? d_val : (-col_val - 11'sd1);
      end else begin
         d_val = col_val - c_val;
         place_reg = (d_val < 11'sd0) || (s_val > d_val + cnt_val);
         disp_val  = place_reg ? d_val : col_val;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      saved_cnt_in = saved_cnt_ff;
      clob_cnt_in  = clob_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      pend_in      = 1'b0;
      idx_in       = idx_ff;
      cls_in       = cls_ff;
      ovf_in       = ovf_ff;
      mask_in      = mask_ff;
      used_in      = used_ff;
      counter_in   = counter_ff;
      scan_in      = scan_ff;
      pend_bit_in  = pend_bit_ff;
      chunk_in     = chunk_ff;
      color_in     = color_ff;
      out_idx_in     = out_idx_ff;
      out_color_in   = out_color_ff;
      out_counter_in = out_counter_ff;
      out_reg_in     = out_reg_ff;
      out_slot_in    = out_slot_ff;
      out_ovf_in     = out_ovf_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // register counts
      if (csr_valid) begin
         unique case (csr_index)
            CsrSavedCount:     saved_cnt_in = csr_data;
            CsrClobberedCount: clob_cnt_in  = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cls_in     = req_is_saved;
               mask_in    = req_neighbor_mask;
               used_in    = '0;
               counter_in = '0;
               scan_in    = '0;
               chunk_in   = '0;
               color_in   = '0;
               if (req_new_graph) begin
                  idx_in = '0;
                  ovf_in = 1'b0;
                  state_in = ST_SCAN;
               end else if (count_ff == count_type'(MaxVertices)) begin
                  idx_in = '0;
                  ovf_in = 1'b1;
                  state_in = ST_PLACE;
               end else begin
                  idx_in = count_ff[VidxWidth-1:0];
                  ovf_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue one store read per cycle, mask bit travels alongside
            if (issue) begin
               pend_in     = 1'b1;
               pend_bit_in = mask_ff[0];
               mask_in     = mask_ff >> 1;
               scan_in     = scan_ff + 7'd1;
            end
            // fold in the entry read last cycle
            if (pend_ff && pend_bit_ff) begin
               if (ram_rd_data[EntryWidth-1] == cls_ff) begin
                  used_in = used_ff | (mask_type'(1) << ram_rd_data[5:0]);
               end else if (counter_ff <= {1'b0, ram_rd_data[5:0]}) begin
                  counter_in = {1'b0, ram_rd_data[5:0]} + 7'd1;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // one byte of the used set per cycle
            if (chunk_bits != 8'hFF) begin
               color_in = {chunk_ff, lowest_zero(chunk_bits)};
               state_in = ST_PLACE;
            end else begin
               chunk_in = chunk_ff + 3'd1;
            end
         end
         ST_PLACE: begin
            // hold until the response register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_ovf_in   = ovf_ff;
               if (ovf_ff) begin
                  out_idx_in     = '0;
                  out_color_in   = '0;
                  out_counter_in = '0;
                  out_reg_in     = 1'b0;
                  out_slot_in    = '0;
               end else begin
                  out_idx_in     = idx_ff;
                  out_color_in   = color_ff;
                  out_counter_in = counter_ff;
                  out_reg_in     = place_reg;
                  out_slot_in    = slot_type'(disp_val[8:0]);
                  count_in       = {1'b0, idx_ff} + 7'd1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         saved_cnt_ff <= '0;
         clob_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         saved_cnt_ff <= saved_cnt_in;
         clob_cnt_ff  <= clob_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      cls_ff         <= cls_in;
      ovf_ff         <= ovf_in;
      mask_ff        <= mask_in;
      used_ff        <= used_in;
      counter_ff     <= counter_in;
      scan_ff        <= scan_in;
      pend_bit_ff    <= pend_bit_in;
      chunk_ff       <= chunk_in;
      color_ff       <= color_in;
      out_idx_ff     <= out_idx_in;
      out_color_ff   <= out_color_in;
      out_counter_ff <= out_counter_in;
      out_reg_ff     <= out_reg_in;
      out_slot_ff    <= out_slot_in;
      out_ovf_ff     <= out_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_vertex_index     = out_idx_ff;
   assign rsp_color_priority   = out_color_ff;
   assign rsp_counter_priority = out_counter_ff;
   assign rsp_in_register      = out_reg_ff;
   assign rsp_slot_offset      = out_slot_ff;
   assign rsp_overflow         = out_ovf_ff;

endmodule

### sv/tcrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the per-vertex class and color store.
module tcrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_class_register_colorer_core: directed rows, then random graphs.
// Depends on tcrc_pkg and colorer RTL only; a predictor or fixed rows give expected placements.
module testbench;
   import tcrc_pkg::*;

   localparam int VertexTarget = 1450;
   localparam int IdlePause    = 80;     // settle time after the last response
   localparam int IdleLimit    = 3000;   // cycles without any handshake before giving up
   localparam int ReportLimit  = 40;
   localparam mask_type AllOnes = '1;
   localparam csr_index_type CsrSpareLow  = 2'd2;
   localparam csr_index_type CsrSpareHigh = 2'd3;

   typedef struct packed {
      vidx_type    vertex_index;
      color_type   color_priority;
      counter_type counter_priority;
      logic        in_register;
      slot_type    slot_offset;
      logic        overflow;
   } placement_type;

   typedef enum logic [1:0] {RowVertex, RowRegister, RowFill} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic          new_graph;
      logic          is_saved;
      mask_type      mask;
      logic          has_fixed;
      placement_type fixed_result;
      csr_index_type index;
      reg_count_type data;   // register value, or vertex count of a fill row
   } stimulus_row_type;

   typedef enum {MaskSparse, MaskHalf, MaskDense, MaskFull} mask_density_type;
   typedef enum {ClassMixed, ClassSaved, ClassClobbered, ClassAlternate} class_pattern_type;
   typedef enum {StallNone, StallCoin, StallThird, StallLong} stall_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_new_graph = 1'b0;
   logic          req_is_saved = 1'b0;
   mask_type      req_neighbor_mask = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   vidx_type      rsp_vertex_index;
   color_type     rsp_color_priority;
   counter_type   rsp_counter_priority;
   logic          rsp_in_register;
   slot_type      rsp_slot_offset;
   logic          rsp_overflow;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = '0;
   reg_count_type csr_data = '0;

   // predictor state: the graph built so far and the register counts
   logic      vertex_class [MaxVertices];
   color_type vertex_color [MaxVertices];
   int        graph_size = 0;
   int        saved_regs = 0;
   int        clobbered_regs = 0;

   placement_type    expected_placements [$];
   stimulus_row_type stimulus_rows [$];

   int failures = 0;
   int vertices_sent = 0;
   int responses_seen = 0;
   int overflow_seen = 0;
   int registers_used = 0;
   int register_writes = 0;
   int settings_used = 0;
   int highest_colour = 0;
   int burst_left = 0;

   two_class_register_colorer_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_new_graph        (req_new_graph),
      .req_is_saved         (req_is_saved),
      .req_neighbor_mask    (req_neighbor_mask),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_vertex_index     (rsp_vertex_index),
      .rsp_color_priority   (rsp_color_priority),
      .rsp_counter_priority (rsp_counter_priority),
      .rsp_in_register      (rsp_in_register),
      .rsp_slot_offset      (rsp_slot_offset),
      .rsp_overflow         (rsp_overflow),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Colour one vertex, place it, and grow the graph unless it is already full.
   function automatic placement_type color_vertex(input logic start, input logic saved_class,
                                                  input mask_type mask);
      placement_type p;
      logic [63:0]   used;
      int            counter, color, d, k;
      p = '0;
      if (start) begin
         graph_size = 0;
      end
      if (graph_size >= MaxVertices) begin
         p.overflow = 1'b1;
         return p;
      end
      used = '0;
      counter = 0;
      for (k = 0; k < graph_size; k++) begin
         if (mask[k]) begin
            if (vertex_class[k] == saved_class) begin
               used[vertex_color[k]] = 1'b1;
            end else if (counter <= int'(vertex_color[k])) begin
               counter = int'(vertex_color[k]) + 1;
            end
         end
      end
      color = 0;
      while (color < 63 && used[color]) begin
         color++;
      end
      // saved class counts down from the top of the saved file; clobbered class
      // fills the clobbered file first, then spills upward into saved registers
      if (saved_class) begin
         d = saved_regs - color - 1;
         p.in_register = (d >= 0 && counter <= d + clobbered_regs);
         p.slot_offset = slot_type'(p.in_register ? d : -color - 1);
      end else begin
         d = color - clobbered_regs;
         p.in_register = (d < 0 || saved_regs > d + counter);
         p.slot_offset = slot_type'(p.in_register ? d : color);
      end
      p.vertex_index     = vidx_type'(graph_size);
      p.color_priority   = color_type'(color);
      p.counter_priority = counter_type'(counter);
      vertex_class[graph_size] = saved_class;
      vertex_color[graph_size] = color_type'(color);
      graph_size++;
      return p;
   endfunction

   function automatic placement_type placed(input int idx, input int color, input int counter,
                                            input logic in_reg, input int slot, input logic ovf);
      placement_type p;
      p.vertex_index     = vidx_type'(idx);
      p.color_priority   = color_type'(color);
      p.counter_priority = counter_type'(counter);
      p.in_register      = in_reg;
      p.slot_offset      = slot_type'(slot);
      p.overflow         = ovf;
      return p;
   endfunction

   function automatic void vertex_row(input logic start, input logic saved, input mask_type mask);
      stimulus_row_type r;
      r = '0;
      r.kind = RowVertex;
      r.new_graph = start;
      r.is_saved = saved;
      r.mask = mask;
      stimulus_rows.push_back(r);
   endfunction

   function automatic void fixed_row(input logic start, input logic saved, input mask_type mask,
                                     input placement_type result);
      stimulus_row_type r;
      r = '0;
      r.kind = RowVertex;
      r.new_graph = start;
      r.is_saved = saved;
      r.mask = mask;
      r.has_fixed = 1'b1;
      r.fixed_result = result;
      stimulus_rows.push_back(r);
   endfunction

   function automatic void register_row(input csr_index_type index, input reg_count_type data);
      stimulus_row_type r;
      r = '0;
      r.kind = RowRegister;
      r.index = index;
      r.data = data;
      stimulus_rows.push_back(r);
   endfunction

   function automatic void fill_row(input logic saved, input reg_count_type count);
      stimulus_row_type r;
      r = '0;
      r.kind = RowFill;
      r.is_saved = saved;
      r.data = count;
      stimulus_rows.push_back(r);
   endfunction

   function automatic mask_type random_mask(input mask_density_type density);
      mask_type a, b, c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case (density)
         MaskSparse: return a & b & c;
         MaskHalf:   return a;
         MaskDense:  return a | b;
         default:    return AllOnes;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      failures++;
      if (failures <= ReportLimit) begin
         $display("ERROR at %0t: %s", $time, what);
      end
   endtask

   task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d: %s is %h, expected %h",
                                   responses_seen, name, got, want));
      end
   endtask

   task automatic check_response();
      placement_type want;
      responses_seen++;
      if (expected_placements.size() == 0) begin
         report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                   responses_seen));
         return;
      end
      want = expected_placements.pop_front();
      check_field("vertex_index", 9'(rsp_vertex_index), 9'(want.vertex_index));
      check_field("color_priority", 9'(rsp_color_priority), 9'(want.color_priority));
      check_field("counter_priority", 9'(rsp_counter_priority), 9'(want.counter_priority));
      check_field("in_register", 9'(rsp_in_register), 9'(want.in_register));
      check_field("slot_offset", rsp_slot_offset, want.slot_offset);
      check_field("overflow", 9'(rsp_overflow), 9'(want.overflow));
      overflow_seen  += int'(want.overflow);
      registers_used += int'(want.in_register);
      if (int'(want.color_priority) > highest_colour) begin
         highest_colour = int'(want.color_priority);
      end
   endtask

   // Present one request in the current burst; open a new burst, sometimes after a gap.
   task automatic send_vertex(input logic start, input logic saved, input mask_type mask,
                              input logic has_fixed, input placement_type fixed_result);
      placement_type predicted;
      int            gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_new_graph     <= start;
      req_is_saved      <= saved;
      req_neighbor_mask <= mask;
      do @(posedge clock); while (!req_ready);
      predicted = color_vertex(start, saved, mask);
      expected_placements.push_back(has_fixed ? fixed_result : predicted);
      vertices_sent++;
   endtask

   // Drop the request line, wait for every response, then let the block settle.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_placements.size() != 0) begin
         @(posedge clock);
      end
      repeat (IdlePause) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input reg_count_type data);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CsrSavedCount) begin
         saved_regs = int'(data);
      end else if (index == CsrClobberedCount) begin
         clobbered_regs = int'(data);
      end
      register_writes++;
   endtask

   // One graph: mostly well formed, now and then a restart or a missing restart.
   task automatic send_graph();
      int                length, v;
      mask_density_type  density;
      class_pattern_type pattern;
      logic              start, saved;
      mask_type          mask;
      length  = ($urandom_range(0, 4) == 0) ? $urandom_range(56, 72) : $urandom_range(1, 24);
      density = mask_density_type'($urandom_range(0, 3));
      pattern = class_pattern_type'($urandom_range(0, 3));
      for (v = 0; v < length; v++) begin
         start = (v == 0);
         if ($urandom_range(0, 39) == 0) begin
            start = !start;
         end
         case (pattern)
            ClassSaved:     saved = ($urandom_range(0, 9) != 0);
            ClassClobbered: saved = ($urandom_range(0, 9) == 0);
            ClassAlternate: saved = v[0];
            default:        saved = 1'($urandom_range(0, 1));
         endcase
         mask = ($urandom_range(0, 29) == 0) ? random_mask(MaskHalf) : random_mask(density);
         send_vertex(start, saved, mask, 1'b0, '0);
      end
   endtask

   // Receiver: check each accepted response, then pick the next ready level.
   initial begin
      stall_mode_type mode;
      int             mode_left, hold, beat;
      logic           stalled, ready_next;
      mode = StallNone;
      mode_left = 0;
      hold = 0;
      beat = 0;
      stalled = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            check_response();
         end
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         case (mode)
            StallCoin: ready_next = 1'($urandom_range(0, 1));
            StallThird: begin
               beat++;
               ready_next = (beat % 3 == 0);
            end
            StallLong: begin
               if (hold == 0) begin
                  stalled = !stalled;
                  hold = stalled ? $urandom_range(1, 20) : $urandom_range(1, 8);
               end
               hold--;
               ready_next = !stalled;
            end
            default: ready_next = 1'b1;
         endcase
         rsp_ready <= reset ? 1'b0 : ready_next;
      end
   end

   // Watchdog: give up once no channel has moved for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= IdleLimit) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     quiet, expected_placements.size());
            $display("testbench failed");
            $finish;
         end
      end
   end

   initial begin
      stimulus_row_type r;
      int               s, c;

      // reset counts: first vertex after reset takes index zero without a restart
      fixed_row(1'b0, 1'b1, AllOnes, placed(0, 0, 0, 1'b0, -1, 1'b0));
      fixed_row(1'b0, 1'b0, '0, placed(1, 0, 0, 1'b0, 0, 1'b0));
      vertex_row(1'b0, 1'b0, AllOnes);
      // full register files, plus writes to indexes the block ignores
      register_row(CsrSavedCount, 8'd255);
      register_row(CsrClobberedCount, 8'd255);
      register_row(CsrSpareLow, 8'h5a);
      register_row(CsrSpareHigh, 8'ha5);
      fixed_row(1'b1, 1'b1, AllOnes, placed(0, 0, 0, 1'b1, 254, 1'b0));
      fixed_row(1'b0, 1'b0, '0, placed(1, 0, 0, 1'b1, -255, 1'b0));
      vertex_row(1'b0, 1'b0, AllOnes);
      // restart mid-graph, then a saved clique up to the top colour and past capacity
      fixed_row(1'b1, 1'b1, '0, placed(0, 0, 0, 1'b1, 254, 1'b0));
      fill_row(1'b1, 8'd63);
      fixed_row(1'b0, 1'b0, AllOnes, placed(0, 0, 0, 1'b0, 0, 1'b1));
      fixed_row(1'b0, 1'b1, '0, placed(0, 0, 0, 1'b0, 0, 1'b1));
      // no saved registers at all
      register_row(CsrSavedCount, 8'd0);
      fixed_row(1'b1, 1'b0, AllOnes, placed(0, 0, 0, 1'b1, -255, 1'b0));
      fixed_row(1'b0, 1'b1, AllOnes, placed(1, 0, 1, 1'b0, -1, 1'b0));
      // no clobbered registers: clobbered vertices spill into saved ones
      register_row(CsrSavedCount, 8'd255);
      register_row(CsrClobberedCount, 8'd0);
      fixed_row(1'b1, 1'b0, '0, placed(0, 0, 0, 1'b1, 0, 1'b0));
      fill_row(1'b0, 8'd20);
      vertex_row(1'b1, 1'b1, 64'ha5a5_5a5a_0f0f_f0f0);
      vertex_row(1'b0, 1'b0, 64'h8000_0000_0000_0001);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stimulus_rows[n]) begin
         r = stimulus_rows[n];
         case (r.kind)
            RowRegister: write_register(r.index, r.data);
            RowFill: begin
               repeat (r.data) send_vertex(1'b0, r.is_saved, AllOnes, 1'b0, '0);
            end
            default: send_vertex(r.new_graph, r.is_saved, r.mask, r.has_fixed, r.fixed_result);
         endcase
      end

      // random phases: a register setting, then a few graphs under it
      while (vertices_sent < VertexTarget) begin
         case ($urandom_range(0, 6))
            0: begin s = 0;   c = 0;   end
            1: begin s = 255; c = 255; end
            2: begin s = 0;   c = $urandom_range(0, 255); end
            3: begin s = $urandom_range(0, 255); c = 0; end
            default: begin
               s = $urandom_range(0, 70);
               c = $urandom_range(0, 70);
            end
         endcase
         if ($urandom_range(0, 3) == 0) begin
            write_register(($urandom_range(0, 1) != 0) ? CsrSpareHigh : CsrSpareLow,
                           reg_count_type'($urandom_range(0, 255)));
         end
         write_register(CsrSavedCount, reg_count_type'(s));
         write_register(CsrClobberedCount, reg_count_type'(c));
         settings_used++;
         repeat ($urandom_range(1, 3)) send_graph();
      end

      wait_until_idle();
      if (expected_placements.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_placements.size()));
      end
      $display("covered %0d vertices, %0d past a full graph, %0d placed in registers",
               vertices_sent, overflow_seen, registers_used);
      $display("%0d register writes over %0d random settings, highest colour %0d",
               register_writes, settings_used, highest_colour);
      if (failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
